### hdl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; every other file references this package by scoped names.
package ffha_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_BADADDR  = 3'd3,
    ST_NOTUSED  = 3'd4,
    ST_ZERO     = 3'd5
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_BASE   = 2'd1,
    REG_SIZE   = 2'd2,
    REG_SPARE  = 2'd3
  } reg_e;

  // Internal operation being sequenced
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RCHECK,
    OP_RALLOC,
    OP_RFREE
  } op_e;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CHK,
    S_FOUND,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SPLIT_WR,
    S_ALLOC_WR,
    S_NXT_RD,
    S_NXT_CHK,
    S_SHDN_RD,
    S_SHDN_WR,
    S_CUR_WR,
    S_PRV_RD,
    S_PRV_CHK,
    S_DONE
  } state_e;

  localparam int unsigned CFG_W  = 32;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned NEED_W = SIZE_W + 1;

  // One block table entry: header offset, payload size, used mark
  typedef struct packed {
    logic [SIZE_W-1:0] off;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [SIZE_W-1:0] copy_length;
    logic [SIZE_W-1:0] used_total;
    logic [SIZE_W-1:0] free_total;
    logic [6:0]        blocks_now;
    logic [6:0]        allocs_now;
  } rsp_t;

  // Heap control from the register block to the sequencer
  typedef struct packed {
    logic              build;
    logic              active;
    logic [ADDR_W-1:0] origin;
    logic [SIZE_W-1:0] payload;
  } heap_ctl_t;

endpackage

### hdl/ffha_mem.sv
// Block table storage: one write port, one read port with registered data.
// Depends on ffha_pkg for the entry type.
module ffha_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ffha_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ffha_pkg::entry_t rdata_o
);

  ffha_pkg::entry_t mem_q [DEPTH];
  ffha_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ffha_match.sv
// Shared scan comparator: first-fit test or data-address match on one entry.
// Depends on ffha_pkg for the entry type and widths.
module ffha_match #(
  parameter int unsigned HEADER_BYTES = 20
) (
  input  ffha_pkg::entry_t                  entry_i,
  input  logic                              find_fit_i,
  input  logic [ffha_pkg::NEED_W-1:0]       need_i,
  input  logic [ffha_pkg::ADDR_W-1:0]       addr_i,
  input  logic [ffha_pkg::ADDR_W-1:0]       origin_i,
  output logic                              hit_o
);

  logic [ffha_pkg::ADDR_W-1:0] data_addr;
  logic                        fit;

  // data address of the entry, wrapping at 32 bits
  assign data_addr = origin_i + ffha_pkg::ADDR_W'(entry_i.off)
                   + ffha_pkg::ADDR_W'(HEADER_BYTES);
  assign fit       = !entry_i.used && ({1'b0, entry_i.size} >= need_i);
  assign hit_o     = find_fit_i ? fit : (data_addr == addr_i);

endmodule

### hdl/ffha_ctrl.sv
// Allocator sequencer: scans, shifts and merges table entries one per step,
// keeps the running counters and the output register. Uses ffha_mem, ffha_match.
module ffha_ctrl #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned HEADER_BYTES    = 20,
  parameter int unsigned ALIGN_BYTES     = 8,
  parameter int unsigned MIN_BLOCK_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::heap_ctl_t heap_ctl_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffha_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffha_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW    = ffha_pkg::SIZE_W;
  localparam int unsigned AW    = ffha_pkg::ADDR_W;
  localparam int unsigned NW    = ffha_pkg::NEED_W;
  localparam logic [SW-1:0]  HDR     = SW'(HEADER_BYTES);
  localparam logic [NW-1:0]  MIN_N   = NW'(MIN_BLOCK_BYTES);
  localparam logic [NW+1:0]  SPLIT_X = (NW + 2)'(HEADER_BYTES + MIN_BLOCK_BYTES);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  ffha_pkg::state_e  state_q, state_d;
  ffha_pkg::op_e     op_q, op_d;
  ffha_pkg::status_e status_q, status_d;
  ffha_pkg::req_t    req_q, req_d;
  ffha_pkg::entry_t  cur_q, cur_d;
  ffha_pkg::rsp_t    out_rsp_q, out_rsp_d;
  logic              find_fit_q, find_fit_d;
  logic              split_q, split_d;
  logic              merge_prev_q, merge_prev_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  idx_q, idx_d, fidx_q, fidx_d, k_q, k_d;
  logic [CNT_W-1:0]  count_q, count_d, active_q, active_d;
  logic [NW-1:0]     need_q, need_d;
  logic [SW-1:0]     used_q, used_d, free_q, free_d, old_q, old_d, copy_q, copy_d;
  logic [AW-1:0]     res_q, res_d;

  // table port
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  ffha_pkg::entry_t  mem_wdata, mem_rdata;
  logic              hit;

  // rounded request size, floor applied
  logic [NW-1:0]     need_raw, need_calc;
  logic              start_alloc, start_free;

  assign need_raw  = NW'((({1'b0, req_q.request_size}) + NW'(ALIGN_BYTES - 1))
                     / ALIGN_BYTES * ALIGN_BYTES);
  assign need_calc = (need_raw < MIN_N) ? MIN_N : need_raw;

  ffha_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffha_match #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_match (
    .entry_i    (mem_rdata),
    .find_fit_i (find_fit_q),
    .need_i     (need_q),
    .addr_i     (req_q.address),
    .origin_i   (heap_ctl_i.origin),
    .hit_o      (hit)
  );

  assign in_ready_o  = (state_q == ffha_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ffha_pkg::S_IDLE;
      op_q         <= ffha_pkg::OP_ALLOC;
      find_fit_q   <= 1'b0;
      split_q      <= 1'b0;
      merge_prev_q <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      active_q     <= '0;
      used_q       <= '0;
      free_q       <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      find_fit_q   <= find_fit_d;
      split_q      <= split_d;
      merge_prev_q <= merge_prev_d;
      out_valid_q  <= out_valid_d;
      count_q      <= count_d;
      active_q     <= active_d;
      used_q       <= used_d;
      free_q       <= free_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    req_q     <= req_d;
    cur_q     <= cur_d;
    out_rsp_q <= out_rsp_d;
    idx_q     <= idx_d;
    fidx_q    <= fidx_d;
    k_q       <= k_d;
    need_q    <= need_d;
    old_q     <= old_d;
    copy_q    <= copy_d;
    res_q     <= res_d;
  end

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    req_d        = req_q;
    cur_d        = cur_q;
    out_rsp_d    = out_rsp_q;
    find_fit_d   = find_fit_q;
    split_d      = split_q;
    merge_prev_d = merge_prev_q;
    out_valid_d  = out_valid_q;
    idx_d        = idx_q;
    fidx_d       = fidx_q;
    k_d          = k_q;
    count_d      = count_q;
    active_d     = active_q;
    need_d       = need_q;
    used_d       = used_q;
    free_d       = free_q;
    old_d        = old_q;
    copy_d       = copy_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    start_alloc  = 1'b0;
    start_free   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // heap build: one free block spanning the heap
    if (heap_ctl_i.build) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '{off: '0, size: heap_ctl_i.payload, used: 1'b0};
      count_d   = ONE_C;
      active_d  = '0;
      used_d    = '0;
      free_d    = heap_ctl_i.payload;
    end

    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          status_d = ffha_pkg::ST_OK;
          res_d    = '0;
          copy_d   = '0;
          state_d  = ffha_pkg::S_DISPATCH;
        end
      end

      ffha_pkg::S_DISPATCH: begin
        if (req_q.command == ffha_pkg::CMD_NONE) begin
          state_d = ffha_pkg::S_DONE;
        end else if (!heap_ctl_i.active) begin
          status_d = ffha_pkg::ST_DISABLED;
          state_d  = ffha_pkg::S_DONE;
        end else begin
          case (req_q.command)
            ffha_pkg::CMD_ALLOC: start_alloc = 1'b1;
            ffha_pkg::CMD_FREE:  start_free  = 1'b1;
            ffha_pkg::CMD_REALLOC: begin
              if (req_q.address == '0) begin
                start_alloc = 1'b1;
              end else if (req_q.request_size == '0) begin
                start_free = 1'b1;
              end else begin
                op_d       = ffha_pkg::OP_RCHECK;
                find_fit_d = 1'b0;
                idx_d      = '0;
                state_d    = ffha_pkg::S_FIND_RD;
              end
            end
            default: state_d = ffha_pkg::S_DONE;
          endcase
        end
      end

      // scan: issue the read of one entry
      ffha_pkg::S_FIND_RD: begin
        if (idx_q >= count_q) begin
          status_d = find_fit_q ? ffha_pkg::ST_NOFIT : ffha_pkg::ST_BADADDR;
          state_d  = ffha_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[IDX_W-1:0];
          state_d   = ffha_pkg::S_FIND_CHK;
        end
      end

      ffha_pkg::S_FIND_CHK: begin
        if (hit) begin
          cur_d   = mem_rdata;
          fidx_d  = idx_q;
          state_d = ffha_pkg::S_FOUND;
        end else begin
          idx_d   = idx_q + ONE_C;
          state_d = ffha_pkg::S_FIND_RD;
        end
      end

      ffha_pkg::S_FOUND: begin
        case (op_q)
          ffha_pkg::OP_ALLOC, ffha_pkg::OP_RALLOC: begin
            if (({2'b00, cur_q.size} >= ({1'b0, need_q} + SPLIT_X))
                && (count_q < MAX_C)) begin
              split_d = 1'b1;
              k_d     = count_q;
              state_d = ffha_pkg::S_SHUP_RD;
            end else begin
              split_d = 1'b0;
              state_d = ffha_pkg::S_ALLOC_WR;
            end
          end
          ffha_pkg::OP_FREE, ffha_pkg::OP_RFREE: begin
            if (!cur_q.used) begin
              status_d = ffha_pkg::ST_NOTUSED;
              state_d  = ffha_pkg::S_DONE;
            end else begin
              used_d     = used_q - cur_q.size;
              free_d     = free_q + cur_q.size;
              if (active_q != '0) begin
                active_d = active_q - ONE_C;
              end
              cur_d.used = 1'b0;
              state_d    = ffha_pkg::S_NXT_RD;
            end
          end
          ffha_pkg::OP_RCHECK: begin
            if (!cur_q.used) begin
              status_d = ffha_pkg::ST_NOTUSED;
              state_d  = ffha_pkg::S_DONE;
            end else if (req_q.request_size <= cur_q.size) begin
              res_d   = req_q.address;
              state_d = ffha_pkg::S_DONE;
            end else begin
              old_d      = cur_q.size;
              op_d       = ffha_pkg::OP_RALLOC;
              need_d     = need_calc;
              find_fit_d = 1'b1;
              idx_d      = '0;
              state_d    = ffha_pkg::S_FIND_RD;
            end
          end
          default: state_d = ffha_pkg::S_DONE;
        endcase
      end

      // open a slot after the chosen block, top entry first
      ffha_pkg::S_SHUP_RD: begin
        if (k_q > (fidx_q + ONE_C)) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(k_q - ONE_C);
          state_d   = ffha_pkg::S_SHUP_WR;
        end else begin
          state_d = ffha_pkg::S_SPLIT_WR;
        end
      end

      ffha_pkg::S_SHUP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[IDX_W-1:0];
        mem_wdata = mem_rdata;
        k_d       = k_q - ONE_C;
        state_d   = ffha_pkg::S_SHUP_RD;
      end

      ffha_pkg::S_SPLIT_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = IDX_W'(fidx_q + ONE_C);
        mem_wdata.off  = cur_q.off + HDR + SW'(need_q);
        mem_wdata.size = cur_q.size - SW'(need_q) - HDR;
        mem_wdata.used = 1'b0;
        count_d        = count_q + ONE_C;
        cur_d.size     = SW'(need_q);
        state_d        = ffha_pkg::S_ALLOC_WR;
      end

      ffha_pkg::S_ALLOC_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = fidx_q[IDX_W-1:0];
        mem_wdata      = cur_q;
        mem_wdata.used = 1'b1;
        used_d         = used_q + cur_q.size;
        free_d         = free_q - cur_q.size;
        active_d       = active_q + ONE_C;
        res_d          = heap_ctl_i.origin + AW'(cur_q.off) + AW'(HEADER_BYTES);
        if (op_q == ffha_pkg::OP_RALLOC) begin
          copy_d     = old_q;
          op_d       = ffha_pkg::OP_RFREE;
          find_fit_d = 1'b0;
          idx_d      = '0;
          state_d    = ffha_pkg::S_FIND_RD;
        end else begin
          state_d = ffha_pkg::S_DONE;
        end
      end

      // merge with the next block when it is free
      ffha_pkg::S_NXT_RD: begin
        if ((fidx_q + ONE_C) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(fidx_q + ONE_C);
          state_d   = ffha_pkg::S_NXT_CHK;
        end else begin
          state_d = ffha_pkg::S_CUR_WR;
        end
      end

      ffha_pkg::S_NXT_CHK: begin
        if (!mem_rdata.used) begin
          cur_d.size   = cur_q.size + HDR + mem_rdata.size;
          k_d          = fidx_q + ONE_C;
          merge_prev_d = 1'b0;
          state_d      = ffha_pkg::S_SHDN_RD;
        end else begin
          state_d = ffha_pkg::S_CUR_WR;
        end
      end

      // close the gap at entry k, bottom entry first
      ffha_pkg::S_SHDN_RD: begin
        if ((k_q + ONE_C) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(k_q + ONE_C);
          state_d   = ffha_pkg::S_SHDN_WR;
        end else begin
          count_d = count_q - ONE_C;
          state_d = merge_prev_q ? ffha_pkg::S_DONE : ffha_pkg::S_CUR_WR;
        end
      end

      ffha_pkg::S_SHDN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[IDX_W-1:0];
        mem_wdata = mem_rdata;
        k_d       = k_q + ONE_C;
        state_d   = ffha_pkg::S_SHDN_RD;
      end

      ffha_pkg::S_CUR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = fidx_q[IDX_W-1:0];
        mem_wdata = cur_q;
        state_d   = ffha_pkg::S_PRV_RD;
      end

      // merge into the previous block when it is free
      ffha_pkg::S_PRV_RD: begin
        if (fidx_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(fidx_q - ONE_C);
          state_d   = ffha_pkg::S_PRV_CHK;
        end else begin
          state_d = ffha_pkg::S_DONE;
        end
      end

      ffha_pkg::S_PRV_CHK: begin
        if (!mem_rdata.used) begin
          mem_we         = 1'b1;
          mem_waddr      = IDX_W'(fidx_q - ONE_C);
          mem_wdata.off  = mem_rdata.off;
          mem_wdata.size = mem_rdata.size + HDR + cur_q.size;
          mem_wdata.used = 1'b0;
          k_d            = fidx_q;
          merge_prev_d   = 1'b1;
          state_d        = ffha_pkg::S_SHDN_RD;
        end else begin
          state_d = ffha_pkg::S_DONE;
        end
      end

      ffha_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_rsp_d.status         = status_q;
          out_rsp_d.result_address = res_q;
          out_rsp_d.copy_length    = copy_q;
          out_rsp_d.used_total     = used_q;
          out_rsp_d.free_total     = free_q;
          out_rsp_d.blocks_now     = 7'(count_q);
          out_rsp_d.allocs_now     = 7'(active_q);
          state_d                  = ffha_pkg::S_IDLE;
        end
      end

      default: state_d = ffha_pkg::S_IDLE;
    endcase

    // command entry points
    if (start_alloc) begin
      if (req_q.request_size == '0) begin
        status_d = ffha_pkg::ST_ZERO;
        state_d  = ffha_pkg::S_DONE;
      end else begin
        op_d       = ffha_pkg::OP_ALLOC;
        need_d     = need_calc;
        find_fit_d = 1'b1;
        idx_d      = '0;
        state_d    = ffha_pkg::S_FIND_RD;
      end
    end
    if (start_free) begin
      if (req_q.address == '0) begin
        state_d = ffha_pkg::S_DONE;
      end else begin
        op_d       = ffha_pkg::OP_FREE;
        find_fit_d = 1'b0;
        idx_d      = '0;
        state_d    = ffha_pkg::S_FIND_RD;
      end
    end
  end

  // table never holds more entries than it has rows
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_C)
    else $error("block count above table depth");

  // blocks in use never outnumber table entries
  a_active_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= count_q)
    else $error("in-use count above block count");

  // a split adds exactly one entry
  a_split_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_SPLIT_WR && !heap_ctl_i.build)
      |=> count_q == $past(count_q) + ONE_C)
    else $error("split did not add one entry");

endmodule

### hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: configuration registers, heap build.
// Depends on ffha_pkg, ffha_ctrl (which holds ffha_mem and ffha_match).

// First-fit heap allocator with coalescing. A command allocates, frees or
// reallocates against an address-ordered block table of MAX_BLOCKS entries held
// in a single-port-write memory. A transaction reads the table one entry at a
// time, scanning for the first fit or the address, then moves entries one by
// one when a split opens a slot or a merge closes one; a new command is taken
// only once the previous response has been registered. Write heap_base and
// heap_size first, then raise heap_enable to build the heap in one cycle.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned HEADER_BYTES    = 20,
  parameter int unsigned ALIGN_BYTES     = 8,
  parameter int unsigned MIN_BLOCK_BYTES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ffha_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ffha_pkg::rsp_t             out_rsp_o
);

  localparam int unsigned SW = ffha_pkg::SIZE_W;
  localparam int unsigned AW = ffha_pkg::ADDR_W;

  logic          enable_q, enable_d, ready_q, ready_d;
  logic [AW-1:0] base_q, base_d, origin_q, origin_d;
  logic [SW-1:0] size_q, size_d;
  logic [AW:0]   org_calc;
  logic [SW-1:0] total;
  logic          build_ok, build;
  ffha_pkg::heap_ctl_t heap_ctl;

  // rounded heap geometry
  assign org_calc = (({1'b0, base_q}) + (AW + 1)'(ALIGN_BYTES - 1))
                    / ALIGN_BYTES * ALIGN_BYTES;
  assign total    = SW'(size_q / ALIGN_BYTES * ALIGN_BYTES);
  assign build_ok = (base_q != '0) && (size_q >= SW'(2 * HEADER_BYTES))
                    && (total > SW'(HEADER_BYTES));

  // configuration writes
  always_comb begin
    enable_d = enable_q;
    ready_d  = ready_q;
    base_d   = base_q;
    size_d   = size_q;
    origin_d = origin_q;
    build    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ffha_pkg::REG_ENABLE: begin
          if (cfg_data_i[0] && !enable_q) begin
            enable_d = 1'b1;
            ready_d  = build_ok;
            build    = build_ok;
            if (build_ok) begin
              origin_d = org_calc[AW-1:0];
            end
          end else if (!cfg_data_i[0]) begin
            enable_d = 1'b0;
            ready_d  = 1'b0;
          end
        end
        ffha_pkg::REG_BASE: base_d = cfg_data_i[AW-1:0];
        ffha_pkg::REG_SIZE: size_d = cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      ready_q  <= 1'b0;
      base_q   <= '0;
      size_q   <= '0;
      origin_q <= '0;
    end else begin
      enable_q <= enable_d;
      ready_q  <= ready_d;
      base_q   <= base_d;
      size_q   <= size_d;
      origin_q <= origin_d;
    end
  end

  assign heap_ctl.build   = build;
  assign heap_ctl.active  = enable_q && ready_q;
  assign heap_ctl.origin  = origin_q;
  assign heap_ctl.payload = total - SW'(HEADER_BYTES);

  ffha_ctrl #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .HEADER_BYTES    (HEADER_BYTES),
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .heap_ctl_i  (heap_ctl),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

### verif/first_fit_heap_allocator_chk.sv
// Checker for the first-fit heap allocator: watches the register port and
// both channels, predicts each response and compares it field by field.
// Depends on ffha_pkg.
module first_fit_heap_allocator_chk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  ffha_pkg::req_t             in_req_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  ffha_pkg::rsp_t             out_rsp_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam int unsigned NBLK = 64;
  localparam logic [23:0] HDR  = 24'd20;
  localparam logic [24:0] MINB = 25'd16;

  // Shadow heap: block table, counters and registers
  logic [23:0] tbl_off [NBLK];
  logic [23:0] tbl_size [NBLK];
  logic        tbl_used [NBLK];
  int unsigned nblk;
  logic [23:0] used_bytes;
  logic [23:0] free_bytes;
  int unsigned nused;
  logic        built;
  logic [31:0] origin;
  logic        en_reg;
  logic [31:0] base_reg;
  logic [23:0] size_reg;

  ffha_pkg::rsp_t expected_rsp_q[$];

  assign pending_o = expected_rsp_q.size();

  function automatic logic [31:0] blk_addr(int unsigned i);
    return origin + 32'(tbl_off[i]) + 32'(HDR);
  endfunction

  function automatic int blk_lookup(logic [31:0] a);
    for (int unsigned i = 0; i < nblk; i++)
      if (blk_addr(i) == a) return i;
    return -1;
  endfunction

  function automatic void heap_build();
    logic [32:0] org;
    logic [23:0] total;
    built = 1'b0;
    if (base_reg == 0 || 25'(size_reg) < 25'(2 * HDR)) return;
    org   = (33'(base_reg) + 33'd7) & ~33'd7;
    total = size_reg & ~24'd7;
    if (total <= HDR) return;
    origin      = org[31:0];
    tbl_off[0]  = '0;
    tbl_size[0] = total - HDR;
    tbl_used[0] = 1'b0;
    nblk        = 1;
    used_bytes  = '0;
    free_bytes  = total - HDR;
    nused       = 0;
    built       = 1'b1;
  endfunction

  function automatic void tbl_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < nblk; k++) begin
      tbl_off[k]  = tbl_off[k+1];
      tbl_size[k] = tbl_size[k+1];
      tbl_used[k] = tbl_used[k+1];
    end
    nblk--;
  endfunction

  function automatic ffha_pkg::status_e heap_alloc(logic [23:0] sz, output logic [31:0] a);
    logic [24:0] need;
    int unsigned i;
    a = '0;
    if (sz == 0) return ffha_pkg::ST_ZERO;
    need = (25'(sz) + 25'd7) & ~25'd7;
    if (need < MINB) need = MINB;
    for (i = 0; i < nblk; i++)
      if (!tbl_used[i] && 25'(tbl_size[i]) >= need) break;
    if (i >= nblk) return ffha_pkg::ST_NOFIT;
    // split when the remainder holds a header and a minimum block
    if (26'(tbl_size[i]) >= 26'(need) + 26'(HDR) + 26'(MINB) && nblk < NBLK) begin
      for (int unsigned k = nblk; k > i + 1; k--) begin
        tbl_off[k]  = tbl_off[k-1];
        tbl_size[k] = tbl_size[k-1];
        tbl_used[k] = tbl_used[k-1];
      end
      tbl_off[i+1]  = tbl_off[i] + HDR + need[23:0];
      tbl_size[i+1] = tbl_size[i] - need[23:0] - HDR;
      tbl_used[i+1] = 1'b0;
      tbl_size[i]   = need[23:0];
      nblk++;
    end
    tbl_used[i] = 1'b1;
    used_bytes  = used_bytes + tbl_size[i];
    free_bytes  = free_bytes - tbl_size[i];
    nused++;
    a = blk_addr(i);
    return ffha_pkg::ST_OK;
  endfunction

  function automatic ffha_pkg::status_e heap_free(logic [31:0] a);
    int found;
    int unsigned i;
    if (a == 0) return ffha_pkg::ST_OK;
    found = blk_lookup(a);
    if (found < 0) return ffha_pkg::ST_BADADDR;
    i = found;
    if (!tbl_used[i]) return ffha_pkg::ST_NOTUSED;
    used_bytes  = used_bytes - tbl_size[i];
    free_bytes  = free_bytes + tbl_size[i];
    if (nused > 0) nused--;
    tbl_used[i] = 1'b0;
    // coalesce with next, then previous
    if (i + 1 < nblk && !tbl_used[i+1]) begin
      tbl_size[i] = tbl_size[i] + HDR + tbl_size[i+1];
      tbl_remove(i + 1);
    end
    if (i > 0 && !tbl_used[i-1]) begin
      tbl_size[i-1] = tbl_size[i-1] + HDR + tbl_size[i];
      tbl_remove(i);
    end
    return ffha_pkg::ST_OK;
  endfunction

  function automatic ffha_pkg::rsp_t heap_request(ffha_pkg::req_t r);
    ffha_pkg::rsp_t    p;
    ffha_pkg::status_e st;
    logic [31:0] res;
    logic [23:0] cp;
    logic [23:0] old;
    int      found;
    st  = ffha_pkg::ST_OK;
    res = '0;
    cp  = '0;
    if (ffha_pkg::cmd_e'(r.command) == ffha_pkg::CMD_NONE) begin
      st = ffha_pkg::ST_OK;
    end else if (!en_reg || !built) begin
      st = ffha_pkg::ST_DISABLED;
    end else if (ffha_pkg::cmd_e'(r.command) == ffha_pkg::CMD_ALLOC) begin
      st = heap_alloc(r.request_size, res);
    end else if (ffha_pkg::cmd_e'(r.command) == ffha_pkg::CMD_FREE) begin
      st = heap_free(r.address);
    end else if (r.address == 0) begin
      st = heap_alloc(r.request_size, res);
    end else if (r.request_size == 0) begin
      st = heap_free(r.address);
    end else begin
      found = blk_lookup(r.address);
      if (found < 0) begin
        st = ffha_pkg::ST_BADADDR;
      end else if (!tbl_used[found]) begin
        st = ffha_pkg::ST_NOTUSED;
      end else if (r.request_size <= tbl_size[found]) begin
        res = r.address;
      end else begin
        old = tbl_size[found];
        st  = heap_alloc(r.request_size, res);
        if (st == ffha_pkg::ST_OK) begin
          cp = old;
          void'(heap_free(r.address));
        end
      end
    end
    p.status         = st;
    p.result_address = res;
    p.copy_length    = cp;
    p.used_total     = used_bytes;
    p.free_total     = free_bytes;
    p.blocks_now     = 7'(nblk);
    p.allocs_now     = 7'(nused);
    return p;
  endfunction

  // Track register writes, predict on input transactions, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    ffha_pkg::rsp_t e;
    if (!rst_ni) begin
      nblk = 0; used_bytes = '0; free_bytes = '0; nused = 0;
      built = 1'b0; origin = '0; en_reg = 1'b0; base_reg = '0; size_reg = '0;
      expected_rsp_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (ffha_pkg::reg_e'(cfg_index_i))
          ffha_pkg::REG_ENABLE: begin
            if (cfg_data_i[0] && !en_reg) begin
              en_reg = 1'b1;
              heap_build();
            end else if (!cfg_data_i[0]) begin
              en_reg = 1'b0;
              built  = 1'b0;
            end
          end
          ffha_pkg::REG_BASE: base_reg = cfg_data_i;
          ffha_pkg::REG_SIZE: size_reg = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_rsp_q.push_back(heap_request(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("ERROR: unexpected response %p", out_rsp_i);
        end else begin
          e = expected_rsp_q.pop_front();
          if (out_rsp_i.status !== e.status || out_rsp_i.result_address !== e.result_address
              || out_rsp_i.copy_length !== e.copy_length
              || out_rsp_i.used_total !== e.used_total
              || out_rsp_i.free_total !== e.free_total
              || out_rsp_i.blocks_now !== e.blocks_now
              || out_rsp_i.allocs_now !== e.allocs_now) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("ERROR: response mismatch");
              $display("  exp st=%0d addr=%h copy=%0d used=%0d free=%0d blk=%0d alc=%0d",
                       e.status, e.result_address, e.copy_length, e.used_total,
                       e.free_total, e.blocks_now, e.allocs_now);
              $display("  got st=%0d addr=%h copy=%0d used=%0d free=%0d blk=%0d alc=%0d",
                       out_rsp_i.status, out_rsp_i.result_address, out_rsp_i.copy_length,
                       out_rsp_i.used_total, out_rsp_i.free_total, out_rsp_i.blocks_now,
                       out_rsp_i.allocs_now);
            end
          end
        end
      end
    end
  end

endmodule

### verif/first_fit_heap_allocator_tb.sv
// Testbench top for the first-fit heap allocator: clock, reset, register
// writes and request stimulus. Depends on ffha_pkg, the DUT and the checker.
module first_fit_heap_allocator_tb;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we;
  logic [1:0]     cfg_index;
  logic [31:0]    cfg_data;
  logic           in_valid;
  logic           in_ready;
  ffha_pkg::req_t in_req;
  logic           out_valid;
  logic           out_ready;
  ffha_pkg::rsp_t out_rsp;
  int             errors;
  int             pending;

  int unsigned tx_idle;
  int unsigned rx_idle;
  logic        rx_hold;
  logic        hold_go;
  logic [31:0] live_addr_q[$];

  first_fit_heap_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  first_fit_heap_allocator_chk i_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off
  always @(posedge clk_i) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Collect granted addresses for later free and reallocate requests
  always @(posedge clk_i) begin
    if (out_valid && out_ready && out_rsp.status == ffha_pkg::ST_OK
        && out_rsp.result_address != 0) begin
      live_addr_q.push_back(out_rsp.result_address);
      if (live_addr_q.size() > 80) void'(live_addr_q.pop_front());
    end
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic cfg_write(ffha_pkg::reg_e idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Enable bit goes with random upper bits
  task automatic heap_setup(logic [31:0] base, logic [31:0] size);
    cfg_write(ffha_pkg::REG_ENABLE, {$urandom()} & ~32'd1);
    cfg_write(ffha_pkg::REG_BASE, base);
    cfg_write(ffha_pkg::REG_SIZE, size);
    cfg_write(ffha_pkg::REG_ENABLE, {$urandom()} | 32'd1);
    live_addr_q.delete();
  endtask

  task automatic send(ffha_pkg::cmd_e c, logic [23:0] sz, logic [31:0] a);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid             <= 1'b1;
    in_req.command       <= c;
    in_req.request_size  <= sz;
    in_req.address       <= a;
    forever begin
      @(negedge clk_i);
      if (in_ready) break;
    end
    @(posedge clk_i);
  endtask

  // Wait for the block to drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] last_addr();
    return (live_addr_q.size() != 0) ? live_addr_q[$] : 32'd0;
  endfunction

  task automatic send_random();
    int unsigned    r;
    ffha_pkg::cmd_e c;
    logic [23:0]    sz;
    logic [31:0]    a;
    r = $urandom_range(99);
    c = (r < 40) ? ffha_pkg::CMD_ALLOC : (r < 70) ? ffha_pkg::CMD_FREE :
        (r < 95) ? ffha_pkg::CMD_REALLOC : ffha_pkg::CMD_NONE;
    r = $urandom_range(99);
    if (r < 50) sz = 24'($urandom_range(64, 1));
    else if (r < 70) sz = 24'($urandom_range(512, 65));
    else if (r < 80) sz = '0;
    else if (r < 90) sz = 24'($urandom());
    else sz = 24'($urandom_range(4000));
    r = $urandom_range(99);
    if (live_addr_q.size() == 0 || r >= 85) a = $urandom();
    else if (r < 60) a = live_addr_q[$urandom_range(live_addr_q.size() - 1)];
    else if (r < 75) a = live_addr_q[$urandom_range(live_addr_q.size() - 1)] + 32'd8;
    else a = '0;
    send(c, sz, a);
  endtask

  initial begin
    logic [31:0] a1;
    logic [31:0] a2;
    rst_ni    = 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= ffha_pkg::REG_ENABLE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    hold_go   = 1'b0;
    tx_idle   = 8;
    rx_idle   = 51;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: disabled heap, failed builds and a minimal heap
    send(ffha_pkg::CMD_ALLOC, 24'd16, '0);
    drain();
    heap_setup(32'd0, 32'd1000);
    send(ffha_pkg::CMD_FREE, 24'd0, 32'd20);
    drain();
    heap_setup(32'h1001, 32'd39);
    send(ffha_pkg::CMD_REALLOC, 24'd8, '0);
    drain();
    heap_setup(32'h1001, 32'd44);
    send(ffha_pkg::CMD_ALLOC, 24'd1, '0);
    send(ffha_pkg::CMD_ALLOC, 24'd1, '0);
    drain();

    // Directed: wrapping origin, largest heap
    heap_setup(32'hFFFF_FFFF, 32'h00FF_FFFF);
    send(ffha_pkg::CMD_ALLOC, 24'd0, '0);
    send(ffha_pkg::CMD_ALLOC, 24'hFF_FFFF, '0);
    send(ffha_pkg::CMD_ALLOC, 24'd1, '0);
    send(ffha_pkg::CMD_ALLOC, 24'd17, '0);
    send(ffha_pkg::CMD_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send(ffha_pkg::CMD_FREE, 24'd0, 32'd0);
    send(ffha_pkg::CMD_FREE, 24'd0, 32'h1234_5678);
    send(ffha_pkg::CMD_REALLOC, 24'd24, 32'd0);
    drain();
    a1 = live_addr_q[0];
    a2 = live_addr_q[1];
    send(ffha_pkg::CMD_REALLOC, 24'd8, a2);
    send(ffha_pkg::CMD_REALLOC, 24'd100, a2);
    send(ffha_pkg::CMD_REALLOC, 24'd0, a1);
    send(ffha_pkg::CMD_FREE, 24'd0, a1);
    send(ffha_pkg::CMD_REALLOC, 24'd40, a1);
    send(ffha_pkg::CMD_REALLOC, 24'hFF_FFFF, last_addr());
    drain();
    send(ffha_pkg::CMD_FREE, 24'd0, last_addr());
    drain();
    // repeated enable and a late base change do not rebuild
    cfg_write(ffha_pkg::REG_BASE, 32'h0000_8000);
    cfg_write(ffha_pkg::REG_ENABLE, 32'd1);
    send(ffha_pkg::CMD_ALLOC, 24'd9, '0);
    drain();

    // Random phases: three idling modes, three heap shapes each
    for (int m = 0; m < 3; m++) begin
      tx_idle = (m == 0) ? 8 : (m == 1) ? 51 : 0;
      rx_idle = (m == 0) ? 51 : (m == 1) ? 8 : 0;
      for (int h = 0; h < 3; h++) begin
        case (h)
          0: heap_setup(32'h0000_1000, 32'd4096);
          1: heap_setup($urandom(), $urandom_range(600, 40));
          default: heap_setup(32'hFFFF_FFF9, 32'h00FF_FFFF);
        endcase
        for (int n = 0; n < 158; n++) begin
          if (m == 0 && h == 0 && n == 40) hold_go = 1'b1;
          send_random();
        end
        drain();
      end
    end

    drain();
    repeat (500) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
